/* hdl/ccf_pkg.sv */
// shared types and constants for the control code text filter
// no dependencies; used by ccf_decide, control_code_text_filter, ccf_clean_checker and testbench

package ccf_pkg;

  localparam int unsigned MAX_KEPT_DEF = 1023;

  localparam logic [7:0] CH_CTRLA = 8'h01;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;

  // per-string flags; the kept byte count lives beside it since its width is a parameter
  typedef struct packed {
    logic [7:0] prev_raw;
    logic       have_prev;
    logic       last_sp;
    logic       skip_next;
    logic       cr_pending;
  } flt_state_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       keep;
    logic       overflow;
  } flt_result_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

/* hdl/ccf_in_if.sv */
// input channel of the filter: one raw byte per request
// no dependencies

interface ccf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

/* hdl/ccf_out_if.sv */
// result channel of the filter: one result per input byte
// no dependencies

interface ccf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_keep;
  logic       out_last;
  logic       out_overflow;

  modport source (output valid, output out_char, output out_keep, output out_last,
                  output out_overflow, input ready);
  modport sink   (input valid, input out_char, input out_keep, input out_last,
                  input out_overflow, output ready);
endinterface

/* hdl/ccf_decide.sv */
// per-byte decision logic: next state and result for one byte
// depends on ccf_pkg

module ccf_decide #(
  parameter int unsigned MAX_KEPT = ccf_pkg::MAX_KEPT_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_KEPT + 1)
) (
  input  ccf_pkg::flt_state_t  st,
  input  logic [CNT_W-1:0]     cnt,
  input  logic [7:0]           c,
  input  logic                 last,
  output ccf_pkg::flt_state_t  st_nxt,
  output logic [CNT_W-1:0]     cnt_nxt,
  output ccf_pkg::flt_result_t res
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

  always_comb begin
    logic       handled;
    logic       emit_req;
    logic [7:0] emit_c;
    logic       blank;

    handled  = 1'b0;
    emit_req = 1'b0;
    emit_c   = ccf_pkg::CH_SP;
    st_nxt   = st;
    cnt_nxt  = cnt;
    res      = '0;
    // unsigned compare against a space; high bit set counts as blank too
    blank    = (c <= ccf_pkg::CH_SP) || c[7];

    if (st.skip_next) begin
      st_nxt.skip_next = 1'b0;
      handled = 1'b1;
    end else if (st.cr_pending) begin
      st_nxt.cr_pending = 1'b0;
      if (c == ccf_pkg::CH_LF) begin
        emit_req = 1'b1;
        handled  = 1'b1;
      end
    end

    if (!handled) begin
      priority if (c == ccf_pkg::CH_CTRLA) begin
        st_nxt.skip_next = 1'b1;
      end else if (blank && st.last_sp) begin
        emit_req = 1'b0;
      end else if (st.have_prev && !ccf_pkg::is_alnum(c) && c == st.prev_raw) begin
        emit_req = 1'b0;
      end else if (c >= ccf_pkg::CH_SP) begin
        emit_req = 1'b1;
        emit_c   = c;
      end else if (c == ccf_pkg::CH_TAB) begin
        emit_req = 1'b1;
      end else if (c == ccf_pkg::CH_CR && !last) begin
        st_nxt.cr_pending = 1'b1;
      end else begin
        emit_req = 1'b0;
      end
    end

    if (emit_req) begin
      if (cnt == CNT_MAX) begin
        res.overflow = 1'b1;
      end else begin
        cnt_nxt        = cnt + 1'b1;
        st_nxt.last_sp = (emit_c == ccf_pkg::CH_SP);
        res.chr        = emit_c;
        res.keep       = 1'b1;
      end
    end

    st_nxt.prev_raw  = c;
    st_nxt.have_prev = 1'b1;

    if (last) begin
      st_nxt  = '0;
      cnt_nxt = '0;
    end
  end

endmodule

/* hdl/control_code_text_filter.sv */
// a byte enters the input register; its result is registered in the result register
// one byte per cycle if not stalled; set by one decision stage and its state loop
// a full result register does not block the input register while it has room
// reset: synchronous active-low rst_n clears both valid flags, string state and count
// top level of the filter; depends on ccf_pkg, ccf_in_if, ccf_out_if and ccf_decide

module control_code_text_filter #(
  parameter int unsigned MAX_KEPT = ccf_pkg::MAX_KEPT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ccf_in_if.sink           in_if,
  ccf_out_if.source        out_if
);

  localparam int unsigned CNT_W = $clog2(MAX_KEPT + 1);

  logic                 s1_valid_r;
  logic [7:0]           s1_char_r;
  logic                 s1_last_r;
  logic                 out_valid_r;
  logic [7:0]           out_char_r;
  logic                 out_keep_r;
  logic                 out_last_r;
  logic                 out_ovf_r;
  ccf_pkg::flt_state_t  st_r;
  ccf_pkg::flt_state_t  st_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  ccf_pkg::flt_result_t res;
  logic                 s2_ready;
  logic                 adv;
  logic                 in_take;

  assign s2_ready = !out_valid_r || out_if.ready;
  assign adv      = s1_valid_r && s2_ready;
  assign in_take  = in_if.valid && in_if.ready;

  assign in_if.ready = !s1_valid_r || s2_ready;

  ccf_decide #(.MAX_KEPT(MAX_KEPT)) u_decide (
    .st     (st_r),
    .cnt    (cnt_r),
    .c      (s1_char_r),
    .last   (s1_last_r),
    .st_nxt (st_nxt),
    .cnt_nxt(cnt_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      cnt_r       <= '0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      // state only moves when a request leaves the input register
      if (adv) begin
        st_r  <= st_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_if.in_char;
      s1_last_r <= in_if.in_last;
    end
    if (adv) begin
      out_char_r <= res.chr;
      out_keep_r <= res.keep;
      out_last_r <= s1_last_r;
      out_ovf_r  <= res.overflow;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.out_char     = out_char_r;
  assign out_if.out_keep     = out_keep_r;
  assign out_if.out_last     = out_last_r;
  assign out_if.out_overflow = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_KEPT))
    else $error("kept count beyond limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> (st_r == '0 && cnt_r == '0))
    else $error("state not cleared after last byte");

  a_keep_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_keep_r && out_ovf_r))
    else $error("result both kept and overflowed");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_keep_r) |-> (out_char_r == 8'h00))
    else $error("dropped result carries a byte");

  a_skip_cr: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.skip_next && st_r.cr_pending))
    else $error("skip and pending cr both set");

endmodule

/* tb/sv/ccf_clean_checker.sv */
// result checker for the control code text filter: watches both channels, predicts each result
// depends on ccf_pkg, ccf_in_if and ccf_out_if

module ccf_clean_checker (
  input  logic clk,
  input  logic rst_n,
  ccf_in_if    byte_mon,
  ccf_out_if   clean_mon,
  output int   fail_n,
  output int   pending_n,
  output int   string_n,
  output int   kept_seen_n,
  output int   ovf_seen_n
);

  typedef struct packed {
    logic [7:0] chr;
    logic       keep;
    logic       last;
    logic       ovf;
  } clean_byte_t;

  // per-string filter state
  logic [7:0]  prev_byte;
  logic        seen_byte;
  logic        space_kept;
  logic        skip_byte;
  logic        cr_held;
  int unsigned kept_n;

  clean_byte_t clean_q[$];
  int          err_n    = 0;
  int          result_n = 0;

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void clear_string();
    prev_byte  = 8'h00;
    seen_byte  = 1'b0;
    space_kept = 1'b0;
    skip_byte  = 1'b0;
    cr_held    = 1'b0;
    kept_n     = 0;
  endfunction

  // keep c unless the length limit is already reached
  function automatic void store_byte(input logic [7:0] c, inout clean_byte_t r);
    if (kept_n >= ccf_pkg::MAX_KEPT_DEF) begin
      r.ovf = 1'b1;
    end else begin
      kept_n++;
      space_kept = (c == ccf_pkg::CH_SP);
      r.chr      = c;
      r.keep     = 1'b1;
    end
  endfunction

  function automatic clean_byte_t filter_byte(input logic [7:0] c, input logic l);
    clean_byte_t r;
    logic        done;
    logic        blank;
    r    = '{chr: 8'h00, keep: 1'b0, last: l, ovf: 1'b0};
    done = 1'b0;
    if (skip_byte) begin
      skip_byte = 1'b0;
      done      = 1'b1;
    end else if (cr_held) begin
      cr_held = 1'b0;
      // cr lf pair: the lf result carries the space
      if (c == ccf_pkg::CH_LF) begin
        store_byte(ccf_pkg::CH_SP, r);
        done = 1'b1;
      end
    end
    if (!done) begin
      // unsigned compare plus the high bit: 0x80..0xff count as blanks
      blank = (c <= ccf_pkg::CH_SP) || c[7];
      if (c == ccf_pkg::CH_CTRLA) begin
        skip_byte = 1'b1;
      end else if (blank && space_kept) begin
      end else if (seen_byte && !is_word_char(c) && c == prev_byte) begin
      end else if (c >= ccf_pkg::CH_SP) begin
        store_byte(c, r);
      end else if (c == ccf_pkg::CH_TAB) begin
        store_byte(ccf_pkg::CH_SP, r);
      end else if (c == ccf_pkg::CH_CR && !l) begin
        cr_held = 1'b1;
      end
    end
    prev_byte = c;
    seen_byte = 1'b1;
    if (l) clear_string();
    return r;
  endfunction

  task automatic flag_error(input string field, input int got, input int want);
    err_n++;
    $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h", result_n, field, got, want);
  endtask

  always @(posedge clk) begin : watch
    clean_byte_t want;
    if (!rst_n) begin
      clear_string();
      clean_q.delete();
    end else begin
      if (clean_mon.valid && clean_mon.ready) begin
        if (clean_q.size() == 0) begin
          flag_error("unexpected result", 1, 0);
        end else begin
          want = clean_q.pop_front();
          if (clean_mon.out_keep !== want.keep)
            flag_error("out_keep", clean_mon.out_keep, want.keep);
          if (clean_mon.out_char !== want.chr)
            flag_error("out_char", clean_mon.out_char, want.chr);
          if (clean_mon.out_last !== want.last)
            flag_error("out_last", clean_mon.out_last, want.last);
          if (clean_mon.out_overflow !== want.ovf)
            flag_error("out_overflow", clean_mon.out_overflow, want.ovf);
        end
        if (clean_mon.out_keep === 1'b1) kept_seen_n <= kept_seen_n + 1;
        if (clean_mon.out_overflow === 1'b1) ovf_seen_n <= ovf_seen_n + 1;
        if (clean_mon.out_last === 1'b1) string_n <= string_n + 1;
        result_n++;
      end
      if (byte_mon.valid && byte_mon.ready)
        clean_q.push_back(filter_byte(byte_mon.in_char, byte_mon.in_last));
    end
    fail_n    <= err_n;
    pending_n <= clean_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
// top of the filter testbench: clock, reset, byte stimulus, receiver stalls and verdict
// depends on ccf_pkg, ccf_in_if, ccf_out_if, control_code_text_filter and ccf_clean_checker

module testbench;

  typedef logic [7:0] text_q_t[$];

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int RAND_ITEMS  = 160;
  localparam int LONG_LEN    = 1030;

  logic clk = 1'b0;
  logic rst_n;

  ccf_in_if  byte_ch();
  ccf_out_if clean_ch();

  int  fail_n;
  int  pending_n;
  int  string_n;
  int  kept_seen_n;
  int  ovf_seen_n;
  int  sent_n   = 0;
  int  quiet_n  = 0;
  int  rx_block = 0;
  bit  idle_on  = 1'b1;
  bit  hold_req = 1'b0;

  control_code_text_filter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (byte_ch),
    .out_if (clean_ch)
  );

  ccf_clean_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_mon    (byte_ch),
    .clean_mon   (clean_ch),
    .fail_n      (fail_n),
    .pending_n   (pending_n),
    .string_n    (string_n),
    .kept_seen_n (kept_seen_n),
    .ovf_seen_n  (ovf_seen_n)
  );

  always #6 clk = ~clk;

  // one request per call; returns at the edge that accepts it
  task automatic send_byte(input logic [7:0] c, input logic l);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_char <= c;
    byte_ch.in_last <= l;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sent_n++;
  endtask

  task automatic send_string(input text_q_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // mostly text-like content with cr lf pairs and control-a pairs; noisy strings use any byte
  function automatic text_q_t make_text(input int len, input bit noisy);
    text_q_t s;
    int      pick;
    while (s.size() < len) begin
      pick = $urandom_range(0, 99);
      if (noisy || pick >= 95)  s.push_back(8'($urandom_range(0, 255)));
      else if (pick < 40)       s.push_back(8'($urandom_range("a", "z")));
      else if (pick < 48)       s.push_back(8'($urandom_range("A", "Z")));
      else if (pick < 55)       s.push_back(8'($urandom_range("0", "9")));
      else if (pick < 70)       s.push_back(ccf_pkg::CH_SP);
      else if (pick < 78)       s.push_back(8'($urandom_range(8'h21, 8'h2F)));
      else if (pick < 83)       s.push_back(ccf_pkg::CH_TAB);
      else if (pick < 89) begin
        s.push_back(ccf_pkg::CH_CR);
        if ($urandom_range(0, 3) != 0) s.push_back(ccf_pkg::CH_LF);
      end else if (pick < 93) begin
        s.push_back(ccf_pkg::CH_CTRLA);
        s.push_back(8'($urandom_range(0, 255)));
      end else begin
        s.push_back(ccf_pkg::CH_LF);
      end
    end
    return s;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    clean_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_block = HOLD_CYCLES;
      end else if (rx_block == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        rx_block = $urandom_range(1, 15);
      end
      if (rst_n && rx_block == 0) begin
        clean_ch.ready <= 1'b1;
      end else begin
        if (rx_block > 0) rx_block--;
        clean_ch.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((byte_ch.valid && byte_ch.ready) || (clean_ch.valid && clean_ch.ready)) quiet_n <= 0;
      else quiet_n <= quiet_n + 1;
      if (quiet_n >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles, %0d results pending",
                 quiet_n, pending_n);
        $display("control_code_text_filter verification failed");
        $finish;
      end
    end
  end

  initial begin
    text_q_t s;
    int      base;
    rst_n           <= 1'b0;
    byte_ch.valid   <= 1'b0;
    byte_ch.in_char <= 8'h00;
    byte_ch.in_last <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // control-a skip, blanks after a kept space, repeats, cr handling, tab, zero byte
    send_string('{8'h41, ccf_pkg::CH_CTRLA, 8'h42, 8'h63});
    send_string('{8'h61, ccf_pkg::CH_SP, ccf_pkg::CH_SP, 8'h80, 8'h00, ccf_pkg::CH_TAB,
                  8'h62});
    send_string('{8'h2D, 8'h2D, 8'h7A, 8'h7A, 8'hFF, ccf_pkg::CH_TAB});
    send_string('{8'h58, ccf_pkg::CH_CR, ccf_pkg::CH_LF, ccf_pkg::CH_CR, 8'h59,
                  ccf_pkg::CH_CR});
    send_string('{ccf_pkg::CH_CTRLA});
    send_string('{ccf_pkg::CH_LF, 8'h00});

    // receiver holds off while bytes keep coming
    hold_req = 1'b1;
    base = sent_n;
    while (sent_n - base < RAND_ITEMS / 2)
      send_string(make_text($urandom_range(1, 40), $urandom_range(0, 9) < 3));

    // one string past the length limit, then the special bytes while over it
    s.delete();
    repeat (LONG_LEN) s.push_back(8'($urandom_range("a", "z")));
    s.push_back(8'h2E);
    s.push_back(ccf_pkg::CH_TAB);
    s.push_back(ccf_pkg::CH_CR);
    s.push_back(ccf_pkg::CH_LF);
    s.push_back(ccf_pkg::CH_SP);
    s.push_back(8'h41);
    send_string(s);

    base = sent_n;
    while (sent_n - base < RAND_ITEMS / 2) begin
      if (sent_n - base > RAND_ITEMS / 4) idle_on = 1'b0;
      send_string(make_text($urandom_range(1, 40), $urandom_range(0, 9) < 3));
    end
    byte_ch.valid <= 1'b0;

    while (pending_n != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d strings: %0d kept, %0d dropped at the length limit",
             sent_n, string_n, kept_seen_n, ovf_seen_n);
    if (fail_n == 0) begin
      $display("control_code_text_filter verification clean");
    end else begin
      $display("%0d mismatches", fail_n);
      $display("control_code_text_filter verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ccf_pkg.sv
hdl/ccf_in_if.sv
hdl/ccf_out_if.sv
hdl/ccf_decide.sv
hdl/control_code_text_filter.sv
tb/sv/ccf_clean_checker.sv
tb/sv/testbench.sv
